@@ design/gtoe_pkg.sv @@
// Shared types, constants and helper functions for the grid tile overlap enumerator.
package gtoe_pkg;

  localparam int MAX_COLUMNS = 8;
  localparam int MAX_ROWS    = 8;
  localparam int CW          = 36;           // wide enough for origin + 8 * tile size
  localparam int IW          = $clog2(MAX_COLUMNS);

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [2:0] {
    REG_BOARD_LEFT   = 3'd0,
    REG_BOARD_TOP    = 3'd1,
    REG_BOARD_RIGHT  = 3'd2,
    REG_BOARD_BOTTOM = 3'd3,
    REG_TILE_WIDTH   = 3'd4,
    REG_TILE_HEIGHT  = 3'd5,
    REG_COLUMN_COUNT = 3'd6,
    REG_ROW_COUNT    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] board_left;
    logic signed [31:0] board_top;
    logic signed [31:0] board_right;
    logic signed [31:0] board_bottom;
    logic [30:0]        tile_width;
    logic [30:0]        tile_height;
    logic [3:0]         column_count;
    logic [3:0]         row_count;
  } cfg_t;

  // One classified query: which columns and which rows hold overlapping tiles.
  typedef struct packed {
    logic [MAX_COLUMNS-1:0] col_mask;
    logic [MAX_ROWS-1:0]    row_mask;
  } job_t;

  function automatic coord_t sext32(input logic [31:0] v);
    sext32 = coord_t'({{(CW-32){v[31]}}, v});
  endfunction

  function automatic coord_t zext31(input logic [30:0] v);
    zext31 = coord_t'({{(CW-31){1'b0}}, v});
  endfunction

  // Lowest set bit of an eight-bit mask.
  function automatic logic [IW-1:0] first_set(input logic [MAX_COLUMNS-1:0] m);
    logic [IW-1:0] idx;
    idx = '0;
    for (int i = MAX_COLUMNS - 1; i >= 0; i--) begin
      if (m[i]) idx = IW'(i);
    end
    first_set = idx;
  endfunction

endpackage

@@ design/grid_tile_overlap_enumerator.sv @@
// Grid tile overlap enumerator: top level with configuration registers.
//
// Usage: write the board bounds, tile size and grid size through the cfg_
// channel (cfg_index selects the register, cfg_data carries its value; the
// channel is always ready). Send a query rectangle on the in_ channel; the
// out_ channel returns one request per overlapping tile in row-major order,
// with out_tlast on the final one. When no tile overlaps, a single request
// with out_tuser (found) low and out_tlast high is returned.
// Timing: the classifier accepts a query, then scans one column and one row
// per cycle over all eight grid positions and hands the masks to the
// emitter; it takes no new query until the masks are pushed. The emitter
// sends one tile per cycle while out_tready is high. A two-entry queue
// between classifier and emitter lets the classifier start the next query
// while tiles drain. When out_tready is low the result register holds and
// the emitter stalls; the queue then fills and in_tready drops. Reset
// returns the registers to board 0, tile size 1, grid 1 x 1 and empties
// all stages.
module grid_tile_overlap_enumerator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // query_left, query_top, query_right, query_bottom
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,  // tile_column[2:0], tile_row[5:3], zero pad
  output logic         out_tuser,  // found
  output logic         out_tlast   // last
);
  import gtoe_pkg::*;

  cfg_t cfg_r;
  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.board_left   <= '0;
      cfg_r.board_top    <= '0;
      cfg_r.board_right  <= '0;
      cfg_r.board_bottom <= '0;
      cfg_r.tile_width   <= 31'd1;
      cfg_r.tile_height  <= 31'd1;
      cfg_r.column_count <= 4'd1;
      cfg_r.row_count    <= 4'd1;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BOARD_LEFT:   cfg_r.board_left   <= cfg_data;
        REG_BOARD_TOP:    cfg_r.board_top    <= cfg_data;
        REG_BOARD_RIGHT:  cfg_r.board_right  <= cfg_data;
        REG_BOARD_BOTTOM: cfg_r.board_bottom <= cfg_data;
        REG_TILE_WIDTH:   cfg_r.tile_width   <= cfg_data[30:0];
        REG_TILE_HEIGHT:  cfg_r.tile_height  <= cfg_data[30:0];
        REG_COLUMN_COUNT: cfg_r.column_count <= cfg_data[3:0];
        REG_ROW_COUNT:    cfg_r.row_count    <= cfg_data[3:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  gtoe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  gtoe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  gtoe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ design/gtoe_queue.sv @@
// Two-entry job queue between the classifier and the tile emitter.
module gtoe_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  gtoe_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output gtoe_pkg::job_t pop_data
);
  import gtoe_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ design/gtoe_front.sv @@
// Query classifier: scans tile columns and rows and builds the overlap masks.
module gtoe_front (
  input  logic           clk,
  input  logic           rst_n,
  input  gtoe_pkg::cfg_t cfg,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [127:0]   in_tdata,
  output logic           push_valid,
  input  logic           push_ready,
  output gtoe_pkg::job_t push_data
);
  import gtoe_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_PUSH} state_t;

  state_t                 st_r;
  logic [IW-1:0]          k_r;
  coord_t                 bx_r, by_r;
  coord_t                 ql_r, qr_r, qt_r, qb_r;
  logic [MAX_COLUMNS-1:0] cm_r;
  logic [MAX_ROWS-1:0]    rm_r;

  coord_t left, top, right, bottom, w, h;
  coord_t endx, endy, tx1, ty1, txlo, txhi, tylo, tyhi;
  coord_t qxlo, qxhi, qylo, qyhi;
  logic   wz, hz, k0;
  logic   c0ok, c1ok, r0ok, r1ok, touchx, touchy, bitx, bity;

  always_comb begin
    left   = sext32(cfg.board_left);
    top    = sext32(cfg.board_top);
    right  = sext32(cfg.board_right);
    bottom = sext32(cfg.board_bottom);
    w      = zext31(cfg.tile_width);
    h      = zext31(cfg.tile_height);
    wz     = (cfg.tile_width == '0);
    hz     = (cfg.tile_height == '0);
    k0     = (k_r == '0);

    endx = bx_r + w;
    endy = by_r + h;
    tx1  = (endx < right)  ? endx : right;
    ty1  = (endy < bottom) ? endy : bottom;
    txlo = (bx_r < tx1) ? bx_r : tx1;
    txhi = (bx_r < tx1) ? tx1 : bx_r;
    tylo = (by_r < ty1) ? by_r : ty1;
    tyhi = (by_r < ty1) ? ty1 : by_r;
    qxlo = (ql_r < qr_r) ? ql_r : qr_r;
    qxhi = (ql_r < qr_r) ? qr_r : ql_r;
    qylo = (qt_r < qb_r) ? qt_r : qb_r;
    qyhi = (qt_r < qb_r) ? qb_r : qt_r;
    touchx = (txlo <= qxhi) && (qxlo <= txhi);
    touchy = (tylo <= qyhi) && (qylo <= tyhi);

    // Start index: k at or past the truncated quotient of the near edge.
    c0ok = wz || (ql_r < endx);
    r0ok = hz || (qt_r < endy);
    // End index: a far edge left of the origin truncates to 0 only within one tile.
    priority if (wz)             c1ok = k0;
    else if (qr_r >= left)       c1ok = (bx_r <= qr_r);
    else                         c1ok = k0 && (qr_r > left - w);
    priority if (hz)             r1ok = k0;
    else if (qb_r >= top)        r1ok = (by_r <= qb_r);
    else                         r1ok = k0 && (qb_r > top - h);

    bitx = c0ok && c1ok && touchx && ({1'b0, k_r} < cfg.column_count);
    bity = r0ok && r1ok && touchy && ({1'b0, k_r} < cfg.row_count);
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign push_valid = (st_r == ST_PUSH);
  assign push_data  = '{col_mask: cm_r, row_mask: rm_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      k_r  <= '0;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            ql_r <= sext32(in_tdata[31:0]);
            qt_r <= sext32(in_tdata[63:32]);
            qr_r <= sext32(in_tdata[95:64]);
            qb_r <= sext32(in_tdata[127:96]);
            bx_r <= left;
            by_r <= top;
            k_r  <= '0;
            st_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cm_r[k_r] <= bitx;
          rm_r[k_r] <= bity;
          bx_r      <= endx;
          by_r      <= endy;
          k_r       <= k_r + 1'b1;
          if (k_r == IW'(MAX_COLUMNS - 1)) st_r <= ST_PUSH;
        end
        ST_PUSH: begin
          if (push_ready) st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/gtoe_back.sv @@
// Tile emitter: walks the overlap masks in row-major order into the result register.
module gtoe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  gtoe_pkg::job_t pop_data,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tuser,
  output logic           out_tlast
);
  import gtoe_pkg::*;

  logic                   busy_r;
  logic [MAX_COLUMNS-1:0] cm_r, crem_r;
  logic [MAX_ROWS-1:0]    rrem_r;
  logic                   ov_r;
  logic [IW-1:0]          oc_r, or_r;
  logic                   of_r, ol_r;

  logic                   can_emit;
  logic [IW-1:0]          c, r;
  logic [MAX_COLUMNS-1:0] crem_nxt;
  logic [MAX_ROWS-1:0]    rrem_nxt;
  logic                   last;
  logic                   pop_empty;
  logic                   do_pop;
  logic                   emit;

  assign can_emit  = !ov_r || out_tready;
  // Hold the job in the queue while the emitter is busy or the result register cannot take a request.
  assign pop_ready = !busy_r && can_emit;
  assign do_pop    = pop_valid && pop_ready;
  assign pop_empty = (pop_data.col_mask == '0) || (pop_data.row_mask == '0);
  assign emit      = busy_r ? can_emit : (do_pop && pop_empty);
  assign c         = first_set(crem_r);
  assign r         = first_set(rrem_r);
  assign crem_nxt  = crem_r & ~(MAX_COLUMNS'(1) << c);
  assign rrem_nxt  = rrem_r & ~(MAX_ROWS'(1) << r);
  assign last      = (crem_nxt == '0) && (rrem_nxt == '0);

  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, or_r, oc_r};
  assign out_tuser  = of_r;
  assign out_tlast  = ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
      if (!busy_r) begin
        if (do_pop) begin
          cm_r   <= pop_data.col_mask;
          crem_r <= pop_data.col_mask;
          rrem_r <= pop_data.row_mask;
          busy_r <= !pop_empty;
          // An empty mask on either axis: one not-found result.
          if (pop_empty) begin
            oc_r <= '0;
            or_r <= '0;
            of_r <= 1'b0;
            ol_r <= 1'b1;
          end
        end
      end else if (can_emit) begin
        oc_r <= c;
        or_r <= r;
        of_r <= 1'b1;
        ol_r <= last;
        if (crem_nxt == '0) begin
          crem_r <= cm_r;
          rrem_r <= rrem_nxt;
        end else begin
          crem_r <= crem_nxt;
        end
        if (last) busy_r <= 1'b0;
      end
    end
  end

  a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !of_r) |-> (ol_r && oc_r == '0 && or_r == '0))
    else $error("not-found result without last or with nonzero tile");
  a_busy_rows: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rrem_r != '0 && crem_r != '0))
    else $error("emitter busy with nothing left to walk");
  a_crem_subset: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ((crem_r & ~cm_r) == '0))
    else $error("column walk outside the column mask");

endmodule

@@ sim/tb_grid_tile_overlap_enumerator.sv @@
// Self-checking testbench for the grid tile overlap enumerator.
module tb_grid_tile_overlap_enumerator;
  import gtoe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 65;

  typedef struct packed {
    logic [2:0] col;
    logic [2:0] row;
    logic       found;
    logic       last;
  } tile_res_t;

  typedef struct {
    bit        typed;
    tile_res_t res;
  } typed_t;

  typedef struct {
    bit           is_cfg;
    reg_idx_t     idx;
    logic [31:0]  data;
    logic [127:0] query;
    bit           typed;
    tile_res_t    res;
  } row_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  cfg_t      grid_cfg;
  tile_res_t tiles_due[$];
  typed_t    typed_q[$];
  row_t      plan[$];
  int        errors;
  int        idle_cycles;
  bit        rx_quiet;
  bit        tx_quiet;
  bit        hold_req;

  grid_tile_overlap_enumerator dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint grid_index(longint coord, longint origin, longint size);
    if (size <= 0) return 0;
    return (coord - origin) / size;
  endfunction

  function automatic bit spans_touch(longint a0, longint a1, longint b0, longint b1);
    longint alo, ahi, blo, bhi;
    alo = (a0 < a1) ? a0 : a1;
    ahi = (a0 < a1) ? a1 : a0;
    blo = (b0 < b1) ? b0 : b1;
    bhi = (b0 < b1) ? b1 : b0;
    return ((alo > blo) ? alo : blo) <= ((ahi < bhi) ? ahi : bhi);
  endfunction

  // Append every tile the query rectangle touches, row-major, to tiles_due, or one not-found result.
  function automatic void predict_tiles(logic [127:0] q);
    longint ql, qt, qr, qb, bl, bt, br, bb, tw, th, cols, rows;
    longint c0, c1, r0, r1, tx0, tx1, ty0, ty1;
    tile_res_t hit[$];
    tile_res_t t;
    ql = longint'($signed(q[31:0]));
    qt = longint'($signed(q[63:32]));
    qr = longint'($signed(q[95:64]));
    qb = longint'($signed(q[127:96]));
    bl = longint'($signed(grid_cfg.board_left));
    bt = longint'($signed(grid_cfg.board_top));
    br = longint'($signed(grid_cfg.board_right));
    bb = longint'($signed(grid_cfg.board_bottom));
    tw = longint'({33'b0, grid_cfg.tile_width});
    th = longint'({33'b0, grid_cfg.tile_height});
    cols = (grid_cfg.column_count > MAX_COLUMNS) ? MAX_COLUMNS : grid_cfg.column_count;
    rows = (grid_cfg.row_count > MAX_ROWS) ? MAX_ROWS : grid_cfg.row_count;
    c0 = grid_index(ql, bl, tw);
    if (c0 < 0) c0 = 0;
    c1 = grid_index(qr, bl, tw);
    if (c1 > cols - 1) c1 = cols - 1;
    r0 = grid_index(qt, bt, th);
    if (r0 < 0) r0 = 0;
    r1 = grid_index(qb, bt, th);
    if (r1 > rows - 1) r1 = rows - 1;
    for (longint r = r0; r <= r1; r++) begin
      ty0 = bt + r * th;
      ty1 = (ty0 + th < bb) ? ty0 + th : bb;
      for (longint c = c0; c <= c1; c++) begin
        tx0 = bl + c * tw;
        tx1 = (tx0 + tw < br) ? tx0 + tw : br;
        if (hit.size() < 64 && spans_touch(tx0, tx1, ql, qr) &&
            spans_touch(ty0, ty1, qt, qb)) begin
          t.col = c[2:0];
          t.row = r[2:0];
          t.found = 1'b1;
          t.last = 1'b0;
          hit = {hit, t};
        end
      end
    end
    if (hit.size() == 0) begin
      t = '{col: 3'd0, row: 3'd0, found: 1'b0, last: 1'b1};
      hit = {hit, t};
    end
    hit[hit.size() - 1].last = 1'b1;
    tiles_due = {tiles_due, hit};
  endfunction

  // Monitor: predict (or take the typed result) on each accepted query, check each accepted result.
  always @(posedge clk) begin
    typed_t    tq;
    tile_res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        tq = typed_q.pop_front();
        if (tq.typed) tiles_due = {tiles_due, tq.res};
        else predict_tiles(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (tiles_due.size() == 0) begin
          report("unexpected result, column", out_tdata[2:0], 0);
        end else begin
          want = tiles_due.pop_front();
          if (out_tdata[2:0] !== want.col) report("tile_column", out_tdata[2:0], want.col);
          if (out_tdata[5:3] !== want.row) report("tile_row", out_tdata[5:3], want.row);
          if (out_tuser !== want.found) report("found", out_tuser, want.found);
          if (out_tlast !== want.last) report("last", out_tlast, want.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stalls, quiet stretches, one long hold-off.
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = rx_quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready) && !hold_req);
    end
  end

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BOARD_LEFT:   grid_cfg.board_left = d;
      REG_BOARD_TOP:    grid_cfg.board_top = d;
      REG_BOARD_RIGHT:  grid_cfg.board_right = d;
      REG_BOARD_BOTTOM: grid_cfg.board_bottom = d;
      REG_TILE_WIDTH:   grid_cfg.tile_width = d[30:0];
      REG_TILE_HEIGHT:  grid_cfg.tile_height = d[30:0];
      REG_COLUMN_COUNT: grid_cfg.column_count = d[3:0];
      default:          grid_cfg.row_count = d[3:0];
    endcase
  endtask

  task automatic send_query(input logic [127:0] q, input bit typed, input tile_res_t res);
    int gap;
    typed_t tq;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tq.typed = typed;
    tq.res = res;
    typed_q = {typed_q, tq};
    in_tdata <= q;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and let every pending result drain.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tiles_due.size() != 0 || typed_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [127:0] rect(longint l, longint t, longint r, longint b);
    return {b[31:0], r[31:0], t[31:0], l[31:0]};
  endfunction

  function automatic void add_cfg(reg_idx_t idx, logic [31:0] d);
    row_t e;
    e = '{is_cfg: 1'b1, idx: idx, data: d, query: '0, typed: 1'b0, res: '0};
    plan = {plan, e};
  endfunction

  function automatic void add_query(logic [127:0] q, bit typed, tile_res_t res);
    row_t e;
    e = '{is_cfg: 1'b0, idx: REG_BOARD_LEFT, data: '0, query: q, typed: typed, res: res};
    plan = {plan, e};
  endfunction

  // Random coordinate around the board span, a tile's margin each side.
  function automatic longint near(longint origin, longint size, longint count);
    longint unsigned span, rnd;
    span = longint'(count + 2) * ((size > 0) ? size : 4) + 1;
    rnd = {$urandom, $urandom};
    return origin - ((size > 0) ? size : 4) + longint'(rnd % span);
  endfunction

  task automatic random_phase(input int kind);
    longint bl, bt, tw, th, cc, rr, br, bb;
    case (kind)
      0: begin
        bl = -64'sd2147483648; bt = -64'sd2147483648;
        tw = 64'h7fffffff; th = 64'h7fffffff; cc = 8; rr = 8;
        br = 64'sd2147483647; bb = 64'sd2147483647;
      end
      1: begin
        bl = 64'sd2147483647; bt = 64'sd2147483647; tw = 0; th = 1;
        cc = 15; rr = 15; br = -64'sd2147483648; bb = -64'sd2147483648;
      end
      default: begin
        bl = $signed($urandom_range(0, 4000)) - 2000;
        bt = $signed($urandom_range(0, 4000)) - 2000;
        tw = (kind == 2) ? $urandom_range(1, 3) : $urandom_range(1, 200);
        th = (kind == 2) ? $urandom_range(1, 3) : $urandom_range(1, 200);
        cc = $urandom_range(0, 9);
        rr = $urandom_range(0, 9);
        br = bl + cc * tw - $urandom_range(0, 2 * tw);
        bb = bt + rr * th - $urandom_range(0, 2 * th);
      end
    endcase
    cfg_write(REG_BOARD_LEFT, bl[31:0]);
    cfg_write(REG_BOARD_TOP, bt[31:0]);
    cfg_write(REG_BOARD_RIGHT, br[31:0]);
    cfg_write(REG_BOARD_BOTTOM, bb[31:0]);
    cfg_write(REG_TILE_WIDTH, tw[31:0]);
    cfg_write(REG_TILE_HEIGHT, th[31:0]);
    cfg_write(REG_COLUMN_COUNT, cc[31:0]);
    cfg_write(REG_ROW_COUNT, rr[31:0]);
  endtask

  initial begin
    tile_res_t none;
    tile_res_t t00;
    longint ql, qt, qr, qb, bl, bt, tw, th;
    int mode;
    none = '{col: 3'd0, row: 3'd0, found: 1'b0, last: 1'b1};
    t00 = '{col: 3'd0, row: 3'd0, found: 1'b1, last: 1'b1};
    errors = 0;
    idle_cycles = 0;
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    grid_cfg = '{board_left: 0, board_top: 0, board_right: 0, board_bottom: 0,
                 tile_width: 1, tile_height: 1, column_count: 1, row_count: 1};

    // Directed rows: reset grid, an 8 x 8 board, oversized and zero counts,
    // zero tile size.
    add_query(rect(0, 0, 0, 0), 1'b1, t00);
    add_query(rect(5, 5, 9, 9), 1'b1, none);
    add_cfg(REG_BOARD_LEFT, -32'sd100);
    add_cfg(REG_BOARD_TOP, -32'sd50);
    add_cfg(REG_BOARD_RIGHT, 32'sd700);
    add_cfg(REG_BOARD_BOTTOM, 32'sd350);
    add_cfg(REG_TILE_WIDTH, 32'd100);
    add_cfg(REG_TILE_HEIGHT, 32'd50);
    add_cfg(REG_COLUMN_COUNT, 32'd8);
    add_cfg(REG_ROW_COUNT, 32'd8);
    add_query(rect(-100, -50, 700, 350), 1'b0, none);
    add_query(rect(700, 350, -100, -50), 1'b0, none);
    add_query(rect(-150, -60, -120, -55), 1'b0, none);
    add_query(rect(-2147483648, -2147483648, 2147483647, 2147483647), 1'b0, none);
    add_query(rect(0, 0, 0, 0), 1'b0, none);
    add_query(rect(250, 120, 260, 20), 1'b0, none);
    add_cfg(REG_COLUMN_COUNT, 32'd15);
    add_cfg(REG_ROW_COUNT, 32'd0);
    add_query(rect(-100, -50, 700, 350), 1'b1, none);
    add_cfg(REG_TILE_WIDTH, 32'd0);
    add_cfg(REG_TILE_HEIGHT, 32'd0);
    add_cfg(REG_ROW_COUNT, 32'd9);
    add_query(rect(-100, -50, -100, -50), 1'b0, none);
    add_query(rect(5000, 5000, -5000, -5000), 1'b0, none);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        cfg_write(plan[i].idx, plan[i].data);
      end else begin
        send_query(plan[i].query, plan[i].typed, plan[i].res);
      end
    end

    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      random_phase(ph);
      rx_quiet = (ph == 4);
      tx_quiet = (ph == 5);
      bl = longint'($signed(grid_cfg.board_left));
      bt = longint'($signed(grid_cfg.board_top));
      tw = longint'({33'b0, grid_cfg.tile_width});
      th = longint'({33'b0, grid_cfg.tile_height});
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 3 && n == 10) hold_req = 1'b1;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
          send_query({$urandom, $urandom, $urandom, $urandom}, 1'b0, none);
        end else begin
          ql = near(bl, tw, grid_cfg.column_count);
          qr = near(bl, tw, grid_cfg.column_count);
          qt = near(bt, th, grid_cfg.row_count);
          qb = near(bt, th, grid_cfg.row_count);
          // order the edges unless this one keeps them in random order
          if (mode != 1) begin
            if (ql > qr) begin ql = ql ^ qr; qr = ql ^ qr; ql = ql ^ qr; end
            if (qt > qb) begin qt = qt ^ qb; qb = qt ^ qb; qt = qt ^ qb; end
          end
          send_query(rect(ql, qt, qr, qb), 1'b0, none);
        end
      end
    end

    wait_idle();
    repeat (30) @(posedge clk);
    if (tiles_due.size() != 0) report("results left over", tiles_due.size(), 0);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ grid_tile_overlap_enumerator.f @@
design/gtoe_pkg.sv
design/gtoe_queue.sv
design/gtoe_front.sv
design/gtoe_back.sv
design/grid_tile_overlap_enumerator.sv
sim/tb_grid_tile_overlap_enumerator.sv
